// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ftm_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel transfer multiply package
// Shared types, constants and the elaboration-time CORDIC angle function.
// ----------------------------------------------------------------------------
package ftm_pkg;

  localparam int PH_W       = 40;  // phase in turns, Q0.40
  localparam int DIM_W      = 13;  // width and height registers
  localparam int RQ_W       = 26;  // radius register
  localparam int HALF_W     = 20;  // coefficient split for the partial products
  localparam int XY_W       = 32;  // CORDIC x and y, Q30
  localparam int CORDIC_FRAC = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 32'sh26DD3B6A;
  localparam logic [XY_W-1:0]        ROUND_HALF   = 32'h2000_0000;
  localparam logic [63:0]            INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH        = 3'd0,
    REG_HEIGHT       = 3'd1,
    REG_RADIUS_QUAD  = 3'd2,
    REG_PHASE_OFFSET = 3'd3,
    REG_COEFF_X      = 3'd4,
    REG_COEFF_Y      = 3'd5
  } ftm_reg_e;

  // Control that travels alongside each sample through the pipeline.
  typedef struct packed {
    logic       valid;
    logic       masked;
    logic [1:0] quad;
  } ftm_ctrl_t;

  // Restoring division, evaluated only while elaborating constants.
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-stage) in turns, Q0.40, from the arctangent series.
  function automatic logic [PH_W-1:0] cordic_angle(input int unsigned stage);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [63:0]  hi;
    int unsigned  e;
    acc = '0;
    if (stage == 0) begin
      return 40'h20_0000_0000;
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = stage * (2 * k + 1);
      if (e <= 62) begin
        term = const_udiv(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    prod = {64'd0, acc} * {64'd0, INV_TWO_PI_Q64};
    hi   = prod[127:64] + 64'd2097152;
    return hi[PH_W+21:22];
  endfunction

endpackage

// ===== sv/ftm_front.sv =====
// ----------------------------------------------------------------------------
// Fresnel transfer multiply front end
// Forms the offsets, their squares, the stop decision and the phase.
// ----------------------------------------------------------------------------
module ftm_front import ftm_pkg::*; #(
  parameter int CW = 12,
  parameter int SW = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [SW-1:0]    re_i,
  input  logic signed [SW-1:0]    im_i,
  input  logic [CW-1:0]           col_i,
  input  logic [CW-1:0]           row_i,
  input  logic [DIM_W-1:0]        width_i,
  input  logic [DIM_W-1:0]        height_i,
  input  logic [RQ_W-1:0]         radius_i,
  input  logic [PH_W-1:0]         offset_i,
  input  logic [PH_W-1:0]         coeff_x_i,
  input  logic [PH_W-1:0]         coeff_y_i,
  output ftm_ctrl_t               ctrl_o,
  output logic signed [PH_W-1:0]  z_o,
  output logic signed [SW-1:0]    re_o,
  output logic signed [SW-1:0]    im_o
);

  localparam int OW   = ((CW + 1 > DIM_W) ? CW + 1 : DIM_W) + 1;
  localparam int SQW  = 2 * OW - 1;
  localparam int CMPW = (SQW + 1 > RQ_W) ? SQW + 1 : RQ_W;
  localparam int PPW  = HALF_W + SQW;
  localparam int NST  = 5;

  logic [NST-1:0]     v_q;
  logic signed [SW-1:0] re_q [NST];
  logic signed [SW-1:0] im_q [NST];

  logic signed [OW-1:0]   ox_d, oy_d, ox_q, oy_q;
  logic signed [2*OW-1:0] sqx_full, sqy_full;
  logic [SQW-1:0]         sqx_q, sqy_q;
  logic [SQW:0]           sq_sum;
  logic                   mask_d, mask2_q, mask3_q, mask4_q;
  logic [PPW-1:0]         pxl_d, pxh_full, pyl_d, pyh_full;
  logic [PPW-1:0]         pxl_q, pyl_q;
  logic [HALF_W-1:0]      pxh_q, pyh_q;
  logic [PH_W-1:0]        px_q, py_q, ph_q;
  logic [1:0]             quad;

  assign ox_d = OW'($signed({1'b0, col_i, 1'b0})) - OW'($signed({1'b0, width_i}));
  assign oy_d = OW'($signed({1'b0, row_i, 1'b0})) - OW'($signed({1'b0, height_i}));

  assign sqx_full = ox_q * ox_q;
  assign sqy_full = oy_q * oy_q;

  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign mask_d = CMPW'(sq_sum) < CMPW'(radius_i);

  // Only the low 40 bits of coefficient times square matter, so the upper
  // half of the coefficient needs only the low HALF_W bits of its product.
  assign pxl_d    = PPW'(coeff_x_i[HALF_W-1:0]) * PPW'(sqx_q);
  assign pxh_full = PPW'(coeff_x_i[PH_W-1:HALF_W]) * PPW'(sqx_q);
  assign pyl_d    = PPW'(coeff_y_i[HALF_W-1:0]) * PPW'(sqy_q);
  assign pyh_full = PPW'(coeff_y_i[PH_W-1:HALF_W]) * PPW'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q[0] <= re_i;
      im_q[0] <= im_i;
      for (int i = 1; i < NST; i++) begin
        re_q[i] <= re_q[i-1];
        im_q[i] <= im_q[i-1];
      end
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      sqx_q   <= sqx_full[SQW-1:0];
      sqy_q   <= sqy_full[SQW-1:0];
      mask2_q <= mask_d;
      pxl_q   <= pxl_d;
      pyl_q   <= pyl_d;
      pxh_q   <= pxh_full[HALF_W-1:0];
      pyh_q   <= pyh_full[HALF_W-1:0];
      mask3_q <= mask2_q;
      px_q    <= PH_W'(pxl_q) + {pxh_q, {(PH_W-HALF_W){1'b0}}};
      py_q    <= PH_W'(pyl_q) + {pyh_q, {(PH_W-HALF_W){1'b0}}};
      mask4_q <= mask3_q;
      ph_q    <= offset_i - px_q - py_q;
    end
  end

  // Quadrant by rounding to the nearest quarter turn; the residual stays
  // within an eighth of a turn.
  assign quad = ph_q[PH_W-1:PH_W-2] + {1'b0, ph_q[PH_W-3]};
  assign z_o  = {ph_q[PH_W-1:PH_W-2] - quad, ph_q[PH_W-3:0]};

  assign ctrl_o = '{valid: v_q[NST-1], masked: mask4_q, quad: quad};
  assign re_o   = re_q[NST-1];
  assign im_o   = im_q[NST-1];

endmodule

// ===== sv/ftm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Fresnel transfer multiply CORDIC cell
// One rotation-mode micro-rotation; the sample rides along to the next cell.
// ----------------------------------------------------------------------------
module ftm_cordic_cell import ftm_pkg::*; #(
  parameter int STAGE = 0,
  parameter int SW    = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ftm_ctrl_t               ctrl_i,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [PH_W-1:0]  z_i,
  input  logic signed [SW-1:0]    re_i,
  input  logic signed [SW-1:0]    im_i,
  output ftm_ctrl_t               ctrl_o,
  output logic signed [XY_W-1:0]  x_o,
  output logic signed [XY_W-1:0]  y_o,
  output logic signed [PH_W-1:0]  z_o,
  output logic signed [SW-1:0]    re_o,
  output logic signed [SW-1:0]    im_o
);

  localparam logic signed [PH_W-1:0] Angle = cordic_angle(STAGE);

  logic signed [XY_W-1:0] dx, dy;
  logic                   fwd;

  assign dx  = y_i >>> STAGE;
  assign dy  = x_i >>> STAGE;
  assign fwd = !z_i[PH_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o  <= fwd ? x_i - dx : x_i + dx;
      y_o  <= fwd ? y_i + dy : y_i - dy;
      z_o  <= fwd ? z_i - Angle : z_i + Angle;
      re_o <= re_i;
      im_o <= im_i;
    end
  end

endmodule

// ===== sv/ftm_back.sv =====
// ----------------------------------------------------------------------------
// Fresnel transfer multiply back end
// Quadrant fold, complex multiply, rounding, saturation and zeroing of stopped samples.
// ----------------------------------------------------------------------------
module ftm_back import ftm_pkg::*; #(
  parameter int SW = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  ftm_ctrl_t               ctrl_i,
  input  logic signed [XY_W-1:0]  x_i,
  input  logic signed [XY_W-1:0]  y_i,
  input  logic signed [SW-1:0]    re_i,
  input  logic signed [SW-1:0]    im_i,
  output logic                    valid_o,
  output logic signed [SW-1:0]    re_o,
  output logic signed [SW-1:0]    im_o,
  output logic                    masked_o
);

  localparam int MW = SW + XY_W;
  localparam int PW = MW + 1;

  logic signed [XY_W-1:0] c, s;
  logic signed [MW-1:0]   ac_q, bs_q, bc_q, as_q;
  logic                   v_q, m_q;
  logic signed [PW-1:0]   sre, sim, tre, tim, rre, rim;
  logic signed [SW-1:0]   sat_re, sat_im;

  always_comb begin
    case (ctrl_i.quad)
      2'd1: begin
        c = -y_i;
        s = x_i;
      end
      2'd2: begin
        c = -x_i;
        s = -y_i;
      end
      2'd3: begin
        c = y_i;
        s = -x_i;
      end
      default: begin
        c = x_i;
        s = y_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= ctrl_i.valid;
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q      <= ctrl_i.masked;
      ac_q     <= re_i * c;
      bs_q     <= im_i * s;
      bc_q     <= im_i * c;
      as_q     <= re_i * s;
      masked_o <= m_q;
      re_o     <= m_q ? '0 : sat_re;
      im_o     <= m_q ? '0 : sat_im;
    end
  end

  always_comb begin
    sre = PW'(ac_q) - PW'(bs_q);
    sim = PW'(bc_q) + PW'(as_q);
    tre = sre + PW'(ROUND_HALF);
    tim = sim + PW'(ROUND_HALF);
    rre = tre >>> CORDIC_FRAC;
    rim = tim >>> CORDIC_FRAC;
    // The value fits when the sample's sign bit and all bits above it agree.
    if ((&rre[PW-1:SW-1]) || !(|rre[PW-1:SW-1])) begin
      sat_re = rre[SW-1:0];
    end else begin
      sat_re = rre[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    if ((&rim[PW-1:SW-1]) || !(|rim[PW-1:SW-1])) begin
      sat_im = rim[SW-1:0];
    end else begin
      sat_im = rim[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// ===== sv/fresnel_transfer_multiply.sv =====
// Streams one spectrum sample per clock while in_ready_o is high; results leave in order
// through five front-end stages for offsets, squares, split coefficient products and phase,
// one cell per CORDIC micro-rotation, two stages for the complex multiply and rounding, and
// one output register. A one-entry skid stage behind that register keeps in_ready_o
// independent of out_ready_i; the pipeline stalls only when the skid entry is full and never
// drops a transaction. The user must write configuration registers via cfg_we_i, cfg_index_i
// and cfg_data_i while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// Fresnel transfer multiply
// Rotates each spectrum sample by the Fresnel phase or stops it near DC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fresnel_transfer_multiply import ftm_pkg::*; #(
  parameter int MAX_DIM       = 4096,
  parameter int SAMPLE_WIDTH  = 24,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im_i,
  input  logic [$clog2(MAX_DIM)-1:0]     col_i,
  input  logic [$clog2(MAX_DIM)-1:0]     row_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_re_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_im_o,
  output logic                           masked_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = SAMPLE_WIDTH;
  localparam int N  = CORDIC_STAGES;

  logic [DIM_W-1:0] width_q, height_q;
  logic [RQ_W-1:0]  radius_q;
  logic [PH_W-1:0]  offset_q, coeff_x_q, coeff_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_W'(1024);
      height_q  <= DIM_W'(1024);
      radius_q  <= '0;
      offset_q  <= '0;
      coeff_x_q <= '0;
      coeff_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:        width_q   <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:       height_q  <= cfg_data_i[DIM_W-1:0];
        REG_RADIUS_QUAD:  radius_q  <= cfg_data_i[RQ_W-1:0];
        REG_PHASE_OFFSET: offset_q  <= cfg_data_i[PH_W-1:0];
        REG_COEFF_X:      coeff_x_q <= cfg_data_i[PH_W-1:0];
        REG_COEFF_Y:      coeff_y_q <= cfg_data_i[PH_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;

  ftm_ctrl_t            ctrl [N+1];
  logic signed [XY_W-1:0] xs [N+1];
  logic signed [XY_W-1:0] ys [N+1];
  logic signed [PH_W-1:0] zs [N+1];
  logic signed [SW-1:0]   res [N+1];
  logic signed [SW-1:0]   ims [N+1];

  ftm_front #(.CW(CW), .SW(SW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .re_i      (in_re_i),
    .im_i      (in_im_i),
    .col_i     (col_i),
    .row_i     (row_i),
    .width_i   (width_q),
    .height_i  (height_q),
    .radius_i  (radius_q),
    .offset_i  (offset_q),
    .coeff_x_i (coeff_x_q),
    .coeff_y_i (coeff_y_q),
    .ctrl_o    (ctrl[0]),
    .z_o       (zs[0]),
    .re_o      (res[0]),
    .im_o      (ims[0])
  );

  assign xs[0] = INV_GAIN_Q30;
  assign ys[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    ftm_cordic_cell #(.STAGE(g), .SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl[g]),
      .x_i    (xs[g]),
      .y_i    (ys[g]),
      .z_i    (zs[g]),
      .re_i   (res[g]),
      .im_i   (ims[g]),
      .ctrl_o (ctrl[g+1]),
      .x_o    (xs[g+1]),
      .y_o    (ys[g+1]),
      .z_o    (zs[g+1]),
      .re_o   (res[g+1]),
      .im_o   (ims[g+1])
    );
  end

  logic                 p_valid, p_masked;
  logic signed [SW-1:0] p_re, p_im;

  ftm_back #(.SW(SW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctrl_i   (ctrl[N]),
    .x_i      (xs[N]),
    .y_i      (ys[N]),
    .re_i     (res[N]),
    .im_i     (ims[N]),
    .valid_o  (p_valid),
    .re_o     (p_re),
    .im_o     (p_im),
    .masked_o (p_masked)
  );

  // Output register with a skid entry behind it.
  logic                 skid_valid_q;
  logic signed [SW-1:0] skid_re_q, skid_im_q;
  logic                 skid_masked_q;
  logic                 out_stall;
  logic                 out_zero;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign out_zero   = (out_re_o == '0) && (out_im_o == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_stall) begin
      if (en && p_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_o  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_o <= p_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_stall) begin
      if (en && p_valid) begin
        skid_re_q     <= p_re;
        skid_im_q     <= p_im;
        skid_masked_q <= p_masked;
      end
    end else if (skid_valid_q) begin
      out_re_o <= skid_re_q;
      out_im_o <= skid_im_q;
      masked_o <= skid_masked_q;
    end else begin
      out_re_o <= p_re;
      out_im_o <= p_im;
      masked_o <= p_masked;
    end
  end

  `ASSERT_CLK(a_skid_behind_out, !skid_valid_q || out_valid_o, "skid full with empty output")
  `ASSERT_CLK(a_masked_zero, !(out_valid_o && masked_o) || out_zero, "masked result not zero")
  `ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready_i, out_valid_o && !skid_valid_q, "stuck")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Fresnel transfer multiply testbench
// Streams spectrum samples through several register settings with random
// idling on both sides and checks every rotated or stopped sample in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ftm_pkg::*;

  localparam int SW          = 24;
  localparam int STAGES      = 20;
  localparam int DRAIN_WAIT  = 40;
  localparam longint LIMIT   = 2000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [PH_W-1:0] PH_ALL = '1;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic                 masked;
  } sample_t;

  class fresnel_scoreboard;
    logic [DIM_W-1:0] width_q, height_q;
    logic [RQ_W-1:0]  radius_q;
    logic [PH_W-1:0]  offset_q, cx_q, cy_q;
    longint           atan_turns[STAGES];
    sample_t          awaiting[$];
    int               mismatches;

    function new();
      logic [63:0]  acc, term;
      logic [127:0] prod;
      int           e;
      width_q = 1024; height_q = 1024; radius_q = 0;
      offset_q = 0; cx_q = 0; cy_q = 0;
      mismatches = 0;
      atan_turns[0] = longint'(64'd1 << 37);
      for (int i = 1; i < STAGES; i++) begin
        acc = 0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            acc = k[0] ? acc - term : acc + term;
          end
        end
        prod = 128'(acc) * 128'(INV_TWO_PI_Q64);
        atan_turns[i] = longint'((prod[127:64] + 64'd2097152) >> 22);
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_WIDTH:        width_q  = v[DIM_W-1:0];
        REG_HEIGHT:       height_q = v[DIM_W-1:0];
        REG_RADIUS_QUAD:  radius_q = v[RQ_W-1:0];
        REG_PHASE_OFFSET: offset_q = v;
        REG_COEFF_X:      cx_q     = v;
        REG_COEFF_Y:      cy_q     = v;
        default: ;
      endcase
    endfunction

    function logic signed [SW-1:0] round_clip(longint v);
      longint r;
      r = (v + (64'sd1 << 29)) >>> 30;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[SW-1:0];
    endfunction

    // Computes the expected output for one accepted transaction.
    function void note_input(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                             logic [11:0] col, logic [11:0] row);
      sample_t     res;
      longint      ox, oy, x, y, z, dx, dy, c, s, tmp;
      logic [63:0] sqx, sqy, ph, resid;
      logic [1:0]  quad;
      ox = 2 * longint'(col) - longint'(width_q);
      oy = 2 * longint'(row) - longint'(height_q);
      sqx = ox * ox;
      sqy = oy * oy;
      if (sqx + sqy < 64'(radius_q)) begin
        res.re = '0; res.im = '0; res.masked = 1'b1;
        awaiting.push_back(res);
        return;
      end
      ph = (64'(offset_q) - 64'(cx_q) * sqx - 64'(cy_q) * sqy) & 64'(PH_ALL);
      quad = 2'((ph + (64'd1 << 37)) >> 38);
      resid = (ph - (64'(quad) << 38)) & 64'(PH_ALL);
      z = {{24{resid[39]}}, resid[39:0]};
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_turns[i];
        end else begin
          x += dx; y -= dy; z += atan_turns[i];
        end
      end
      c = x; s = y;
      case (quad)
        2'd1: begin tmp = c; c = -s; s = tmp; end
        2'd2: begin c = -c; s = -s; end
        2'd3: begin tmp = c; c = s; s = -tmp; end
        default: ;
      endcase
      res.re = round_clip(longint'(a) * c - longint'(b) * s);
      res.im = round_clip(longint'(b) * c + longint'(a) * s);
      res.masked = 1'b0;
      awaiting.push_back(res);
    endfunction

    function void check_result(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                               logic masked);
      sample_t want;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output: re=%0d im=%0d masked=%0b",
                                       re, im, masked);
        return;
      end
      want = awaiting.pop_front();
      if (re !== want.re || im !== want.im || masked !== want.masked) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected re=%0d im=%0d masked=%0b, got re=%0d im=%0d masked=%0b",
                   want.re, want.im, want.masked, re, im, masked);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, masked_o;
  logic signed [SW-1:0] in_re_i, in_im_i, out_re_o, out_im_o;
  logic [11:0] col_i, row_i;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  fresnel_scoreboard sb = new();
  bit     steady;     // no idling on either side
  bit     hold_req;
  longint cycles;

  fresnel_transfer_multiply u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_re_i, .in_im_i, .col_i, .row_i,
    .out_valid_o, .out_ready_i, .out_re_o, .out_im_o, .masked_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_re_o, out_im_o, masked_o);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  task automatic send_sample(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                             logic [11:0] col, logic [11:0] row);
    int gap;
    in_valid_i <= 1'b1;
    in_re_i <= a; in_im_i <= b; col_i <= col; row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(a, b, col, row);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.awaiting.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Writes all six registers back to back, then one spare index that must be ignored.
  task automatic write_regs(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [RQ_W-1:0] rq,
                            logic [PH_W-1:0] po, logic [PH_W-1:0] cx, logic [PH_W-1:0] cy);
    logic [CFG_DATA_W-1:0] vals[6];
    logic [CFG_DATA_W-1:0] junk;
    vals = '{40'(w) | (40'({$urandom, $urandom}) & 40'hFF_FFFF_E000),
             40'(h), 40'(rq) | (40'({$urandom, $urandom}) & 40'hFF_FC00_0000), po, cx, cy};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    junk = 40'({$urandom, $urandom});
    cfg_index_i <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_data_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_sample(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    logic signed [SW-1:0] a, b;
    logic [11:0] col, row;
    a = SW'($urandom); b = SW'($urandom);
    if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    // Half of the positions fall near the frame centre so the stop radius gets hit.
    if ($urandom_range(0, 1)) begin
      col = 12'((w >> 1) + $urandom_range(0, 40) - 20);
      row = 12'((h >> 1) + $urandom_range(0, 40) - 20);
    end else begin
      col = 12'($urandom); row = 12'($urandom);
    end
    send_sample(a, b, col, row);
  endtask

  initial begin
    logic [DIM_W-1:0] w, h;
    logic [RQ_W-1:0]  rq;
    logic [PH_W-1:0]  quarter[4];
    rst_ni = 1'b0;
    cycles = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    in_valid_i <= 1'b0;
    in_re_i <= '0; in_im_i <= '0; col_i <= '0; row_i <= '0;
    cfg_we_i <= 1'b0; cfg_index_i <= '0; cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then quadrants 0, 1, 2 and 0, mostly full scale.
    send_sample(24'sh7FFFFF, 24'sh800000, 12'd0, 12'd4095);
    send_sample(24'sh000001, 24'sh000000, 12'd512, 12'd512);
    quarter = '{40'h0, 40'h40_0000_0000, 40'h80_0000_0000, 40'hE0_0000_0001};
    foreach (quarter[i]) begin
      drain();
      write_regs(13'd1024, 13'd1024, 26'd0, quarter[i], 40'd0, 40'd0);
      send_sample(24'sh7FFFFF, 24'sh7FFFFF, 12'd0, 12'd0);
      send_sample(24'sh800000, 24'sh800000, 12'd4095, 12'd4095);
      send_sample(24'sh800000, 24'sh7FFFFF, 12'd100, 12'd900);
      send_sample(24'sh123456, 24'shEDCBA9, 12'd2047, 12'd2048);
    end
    // Stop radius at its maximum, width and height at the 13-bit extremes.
    drain();
    write_regs(13'h1FFF, 13'd0, 26'h3FF_FFFF, PH_ALL, PH_ALL, PH_ALL);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF, 12'd4095, 12'd0);
    send_sample(24'sh7FFFFF, 24'sh7FFFFF, 12'd0, 12'd0);
    send_sample(24'sh800000, 24'sh000000, 12'd4095, 12'd4095);

    for (int p = 0; p < 12; p++) begin
      drain();
      case (p % 4)
        0: begin w = 13'd2; h = 13'd4096; end
        1: begin
          w = DIM_W'($urandom_range(2, 4096));
          h = DIM_W'($urandom_range(2, 4096));
        end
        2: begin w = DIM_W'($urandom); h = DIM_W'($urandom); end
        default: begin w = 13'd4096; h = 13'd2; end
      endcase
      case (p % 3)
        0: rq = 0;
        1: rq = RQ_W'($urandom_range(0, 3000));
        default: rq = (p == 5) ? 26'h200_0000 : 26'($urandom);
      endcase
      write_regs(w, h, rq, 40'({$urandom, $urandom}),
                 (p == 3) ? PH_ALL : 40'({$urandom, $urandom}) >> $urandom_range(0, 39),
                 (p == 7) ? PH_ALL : 40'({$urandom, $urandom}) >> $urandom_range(0, 39));
      steady = (p == 2 || p == 9);
      if (p == 4) hold_req = 1'b1;
      repeat (150) random_sample(w, h);
    end

    drain();
    if (sb.mismatches == 0 && sb.awaiting.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== fresnel_transfer_multiply.f =====
+incdir+sv
sv/ftm_pkg.sv
sv/ftm_front.sv
sv/ftm_cordic_cell.sv
sv/ftm_back.sv
sv/fresnel_transfer_multiply.sv
verif/testbench.sv
